// File: design/aba_routing_number_validator_defines.svh
// Assertion macros shared by the validator RTL.
// All macros assume a clock named clk and an active-low reset named rst_n.
`ifndef ABA_ROUTING_NUMBER_VALIDATOR_DEFINES_SVH
`define ABA_ROUTING_NUMBER_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define ABARN_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("abarn: invariant violated");
`define ABARN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abarn: same-cycle implication violated");
`define ABARN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abarn: next-cycle implication violated");
`else
`define ABARN_ASSERT(lbl, expr)
`define ABARN_ASSERT_IMP(lbl, ante, cons)
`define ABARN_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/abarn_pkg.sv
package abarn_pkg;

  localparam int CharW    = 8;
  localparam int ValueW   = 30;
  localparam int StatusW  = 3;
  localparam int CountW   = 4;
  localparam int DigitW   = 4;
  localparam int PrefixW  = 7;
  localparam int OutDataW = 40;  // value + status, padded to bytes

  localparam logic [CharW-1:0]  CharZero  = 8'h30;
  localparam logic [CharW-1:0]  CharNine  = 8'h39;
  localparam logic [CountW-1:0] NumDigits = 4'd9;
  localparam logic [CountW-1:0] CountSat  = 4'd10;

  typedef enum logic [StatusW-1:0] {
    ST_OK           = 3'd0,
    ST_BAD_CHAR     = 3'd1,
    ST_BAD_PREFIX   = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_BAD_LENGTH   = 3'd4
  } status_t;

  typedef struct packed {
    logic              fin;     // string finished this cycle
    logic [ValueW-1:0] value;
    status_t           status;
  } result_t;

  // v mod 10 for v <= 90; q = (v * 205) >> 11 is exact in that range
  function automatic logic [DigitW-1:0] mod10(input logic [PrefixW-1:0] v);
    logic [17:0]        prod;
    logic [DigitW-1:0]  q;
    logic [PrefixW-1:0] r;
    prod = {11'd0, v} * 18'd205;
    q    = prod[14:11];
    r    = v - 7'({q, 3'b000}) - 7'({q, 1'b0});
    return r[DigitW-1:0];
  endfunction

  // Federal Reserve prefix ranges
  function automatic logic prefix_ok(input logic [PrefixW-1:0] p);
    return (p <= 7'd12) || (p >= 7'd21 && p <= 7'd32) ||
           (p >= 7'd61 && p <= 7'd72) || (p == 7'd80);
  endfunction

endpackage

// File: design/aba_routing_number_validator.sv
// Routing-number validator: one character request per cycle, unless a final character waits on a held result.
// The last character passes the input register, then the result register drives out_tvalid.
// Throughput: 1 character/cycle; a held result stalls input only at the next last char.
// Timing path: input register -> digit accumulator -> result register.
// Reset (rst_n low, synchronous): pipeline emptied, running sums and error cleared.
`include "aba_routing_number_validator_defines.svh"

module aba_routing_number_validator
  import abarn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // character stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [CharW-1:0]    in_tdata,   // [7:0] char_code
  input  logic                in_tlast,   // last_char
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata   // [29:0] routing_value, [32:30] status, rest 0
);

  // input register stage
  logic             in_valid_r;
  logic [CharW-1:0] in_char_r;
  logic             in_last_r;

  // result register
  logic                out_valid_r;
  logic [OutDataW-1:0] out_data_r;

  logic    advance;   // registered char is consumed by the accumulator
  logic    out_free;
  result_t res;

  // Only a final character needs room in the result register.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (!in_last_r || out_free);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  abarn_digit_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_code (in_char_r),
    .last_char (in_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.fin) begin
      out_data_r <= {7'd0, res.status, res.value};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `ABARN_ASSERT_IMP(a_err_zero_value, out_valid_r && out_data_r[32:30] != ST_OK,
                    out_data_r[29:0] == '0)
  `ABARN_ASSERT_IMP(a_status_range, out_valid_r, out_data_r[32:30] <= ST_BAD_LENGTH)
  `ABARN_ASSERT_NXT(a_fin_loads, advance && in_last_r, out_valid_r)
  `ABARN_ASSERT_IMP(a_mid_never_stalls, in_valid_r && !in_last_r, advance)

endmodule

// File: design/abarn_digit_acc.sv
`include "aba_routing_number_validator_defines.svh"

module abarn_digit_acc
  import abarn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [CharW-1:0] char_code,
  input  logic             last_char,
  output result_t          res
);

  logic [CountW-1:0] count_r;
  logic [ValueW-1:0] value_r;
  logic [DigitW-1:0] first_digit_r;
  logic [DigitW-1:0] chk_r;          // running 7-3-9 weighted sum mod 10
  status_t           err_r;

  logic               is_digit;
  logic [CharW-1:0]   char_off;
  logic [DigitW-1:0]  digit;
  logic [DigitW-1:0]  weight;
  logic [7:0]         wprod;
  logic [PrefixW-1:0] chk_sum;
  logic [DigitW-1:0]  chk_nxt;
  logic [PrefixW-1:0] prefix;
  status_t            new_err;
  status_t            err_seen;
  status_t            err_fin;
  logic [CountW-1:0]  count_nxt;
  logic [ValueW-1:0]  value_nxt;

  assign is_digit = (char_code >= CharZero) && (char_code <= CharNine);
  assign char_off = char_code - CharZero;
  assign digit    = char_off[DigitW-1:0];

  always_comb begin
    unique case (count_r)
      4'd0, 4'd3, 4'd6: weight = 4'd7;
      4'd1, 4'd4, 4'd7: weight = 4'd3;
      4'd2, 4'd5:       weight = 4'd9;
      default:          weight = 4'd0;
    endcase
  end

  assign wprod   = {4'd0, weight} * {4'd0, digit};
  assign chk_sum = wprod[PrefixW-1:0] + {3'd0, chk_r};
  assign chk_nxt = mod10(chk_sum);
  assign prefix  = 7'({first_digit_r, 3'b000}) + 7'({first_digit_r, 1'b0}) + {3'd0, digit};

  always_comb begin
    priority if (!is_digit) begin
      new_err = ST_BAD_CHAR;
    end else if (count_r == 4'd1 && !prefix_ok(prefix)) begin
      new_err = ST_BAD_PREFIX;
    end else if (count_r == 4'd8 && digit != chk_r) begin
      new_err = ST_BAD_CHECKSUM;
    end else begin
      new_err = ST_OK;
    end
  end

  assign count_nxt = (is_digit && count_r < CountSat) ? count_r + 4'd1 : count_r;
  assign value_nxt = (is_digit && count_r < NumDigits)
                   ? 30'({value_r, 3'b000}) + 30'({value_r, 1'b0}) + 30'(digit)
                   : value_r;
  assign err_seen  = (err_r == ST_OK) ? new_err : err_r;
  assign err_fin   = (err_seen == ST_OK && count_nxt != NumDigits) ? ST_BAD_LENGTH : err_seen;

  assign res.fin    = step && last_char;
  assign res.status = err_fin;
  assign res.value  = (err_fin == ST_OK) ? value_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_char)) begin
      count_r       <= '0;
      value_r       <= '0;
      first_digit_r <= '0;
      chk_r         <= '0;
      err_r         <= ST_OK;
    end else if (step) begin
      count_r <= count_nxt;
      value_r <= value_nxt;
      err_r   <= err_seen;
      if (is_digit) begin
        chk_r <= chk_nxt;
      end
      if (is_digit && count_r == 4'd0) begin
        first_digit_r <= digit;
      end
    end
  end

  `ABARN_ASSERT(a_count_sat, count_r <= CountSat)
  `ABARN_ASSERT_NXT(a_fin_clears, step && last_char, count_r == '0 && err_r == ST_OK)
  `ABARN_ASSERT_NXT(a_bad_char_sticks, step && !last_char && !is_digit, err_r != ST_OK)

endmodule

// File: dv/tb.sv
module tb;
  import abarn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One routing-number string as raw character bytes
  typedef logic [CharW-1:0] char_q_t[$];

  // One result as the block should report it
  typedef struct {
    logic [ValueW-1:0] value;
    status_t           status;
  } routing_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [CharW-1:0]    in_tdata = '0;    // [7:0] char_code
  logic                in_tlast = 1'b0;  // last_char
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;        // [29:0] routing_value, [32:30] status

  // Idle rates in percent, changed per phase
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned n_errors = 0;

  // Results still owed by the block, oldest first
  routing_result_t pending_results[$];

  // Shadow copy of the validator's running state
  logic [CountW-1:0]  acc_count;
  logic [ValueW-1:0]  acc_value;
  logic [PrefixW-1:0] acc_prefix;
  logic [4:0]         acc_sum1;
  logic [4:0]         acc_sum2;
  logic [4:0]         acc_sum3;
  status_t            acc_fault;

  aba_routing_number_validator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow validator
  // ---------------------------------------------------------------------------

  function automatic void clear_shadow();
    acc_count  = '0;
    acc_value  = '0;
    acc_prefix = '0;
    acc_sum1   = '0;
    acc_sum2   = '0;
    acc_sum3   = '0;
    acc_fault  = ST_OK;
  endfunction

  // Only the first fault of a string sticks
  function automatic void record_fault(input status_t code);
    if (acc_fault == ST_OK) begin
      acc_fault = code;
    end
  endfunction

  // Advance the shadow state by one accepted character; on the last one
  // queue the result the block owes us and start over.
  function automatic void validate_char(input logic [CharW-1:0] ch, input logic last);
    int unsigned     d;
    int unsigned     pos;
    int unsigned     pfx;
    routing_result_t res;
    if (ch >= CharZero && ch <= CharNine) begin
      d   = ch - CharZero;
      pos = acc_count;
      if (pos < 9) acc_value = ValueW'(acc_value * 10 + d);
      if (pos < 2) acc_prefix = PrefixW'(acc_prefix * 10 + d);
      case (pos)
        0, 3, 6: acc_sum1 += 5'(d);
        1, 4, 7: acc_sum2 += 5'(d);
        2, 5:    acc_sum3 += 5'(d);
        8: begin
          if (d != (7 * acc_sum1 + 3 * acc_sum2 + 9 * acc_sum3) % 10) begin
            record_fault(ST_BAD_CHECKSUM);
          end
        end
        default: ;
      endcase
      pfx = acc_prefix;
      if (pos == 1 && !(pfx <= 12 || (pfx >= 21 && pfx <= 32) ||
                        (pfx >= 61 && pfx <= 72) || pfx == 80)) begin
        record_fault(ST_BAD_PREFIX);
      end
      if (acc_count < CountSat) acc_count++;
    end else begin
      record_fault(ST_BAD_CHAR);
    end
    if (last) begin
      if (acc_count != NumDigits) record_fault(ST_BAD_LENGTH);
      res.status = acc_fault;
      res.value  = (acc_fault == ST_OK) ? acc_value : '0;
      pending_results.push_back(res);
      clear_shadow();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus the scoreboard check
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    routing_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d", $time,
                 out_tdata[ValueW-1:0], out_tdata[ValueW+StatusW-1:ValueW]);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[ValueW-1:0] !== want.value) begin
          $display("%0t: routing_value expected %0d actual %0d", $time,
                   want.value, out_tdata[ValueW-1:0]);
          n_errors++;
        end
        if (out_tdata[ValueW+StatusW-1:ValueW] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, out_tdata[ValueW+StatusW-1:ValueW]);
          n_errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One character request; valid stays high after acceptance so the next
  // call can follow back to back.
  task automatic send_char(input logic [CharW-1:0] ch, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    validate_char(ch, last);
  endtask

  task automatic send_string(input char_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  // Sender holds off until the block has delivered everything
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic char_q_t digits(input longint unsigned v, input int n);
    char_q_t q;
    for (int i = 0; i < n; i++) begin
      q.push_front(CharW'(CharZero + v % 10));
      v /= 10;
    end
    return q;
  endfunction

  // Two-digit prefix + six middle digits + the matching 7-3-9 check digit
  function automatic char_q_t routing_num(input int unsigned pfx, input int unsigned mid);
    char_q_t     q;
    int unsigned w;
    q = digits(longint'(pfx) * 1000000 + mid % 1000000, 8);
    w = 7 * (q[0] + q[3] + q[6] - 3 * CharZero) +
        3 * (q[1] + q[4] + q[7] - 3 * CharZero) +
        9 * (q[2] + q[5] - 2 * CharZero);
    q.push_back(CharW'(CharZero + w % 10));
    return q;
  endfunction

  function automatic logic [CharW-1:0] non_digit();
    logic [CharW-1:0] b;
    do b = CharW'($urandom_range(255)); while (b >= CharZero && b <= CharNine);
    return b;
  endfunction

  function automatic int unsigned good_prefix();
    case ($urandom_range(3))
      0:       return $urandom_range(12);
      1:       return $urandom_range(32, 21);
      2:       return $urandom_range(72, 61);
      default: return 80;
    endcase
  endfunction

  function automatic int unsigned bad_prefix();
    case ($urandom_range(3))
      0:       return $urandom_range(20, 13);
      1:       return $urandom_range(60, 33);
      2:       return $urandom_range(79, 73);
      default: return $urandom_range(99, 81);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_valid_numbers();
    send_string(digits(11000015, 9));                 // well-known good number
    send_string(digits(0, 9));                        // all zeros, smallest value
    send_string(routing_num(80, 9999999));            // largest accepted value
    send_string(routing_num(12, 3456789));            // prefix range edges
    send_string(routing_num(21, 0));
    send_string(routing_num(32, 1111111));
    send_string(routing_num(61, 7654321));
    send_string(routing_num(72, 5000000));
    wait_all_results();
  endtask

  task automatic test_bad_chars();
    char_q_t s;
    s = digits(11000015, 9);
    s[5] = "A";
    send_string(s);                                   // non-digit mid string
    send_char(8'h00, 1'b1);                           // lone zero byte
    send_char(8'hFF, 1'b1);                           // lone all-ones byte
    send_string('{"0", "1", "/", ":"});               // neighbors of the digit range
    s = routing_num(13, 0);
    s[4] = "x";
    send_string(s);                                   // bad prefix seen first, wins
    send_string('{"x", "1"});                         // bad char beats short length
    wait_all_results();
  endtask

  task automatic test_prefixes();
    send_string(routing_num(13, 1234567));
    send_string(routing_num(20, 0));
    send_string(routing_num(33, 0));
    send_string(routing_num(60, 0));
    send_string(routing_num(73, 0));
    send_string(routing_num(79, 0));
    send_string(routing_num(81, 0));
    send_string(digits(999999999, 9));                // top of the field, bad prefix
    wait_all_results();
  endtask

  task automatic test_checksum();
    char_q_t s;
    send_string(digits(11000016, 9));                 // check digit off by one
    s = digits(11000016, 9);
    s.push_back("3");
    send_string(s);                                   // checksum fault beats length
    s = digits(11000015, 9);
    s.push_back("7");
    send_string(s);                                   // good nine, then an extra digit
    wait_all_results();
  endtask

  task automatic test_lengths();
    send_char("5", 1'b1);                             // single digit, no prefix check
    send_string(digits(1, 2));                        // two digits, good prefix
    send_string(digits(1100001, 8));
    send_string(digits(64'd12345678901234, 14));      // count saturates
    wait_all_results();
  endtask

  // Mostly well-formed numbers with random content, the rest broken or noise
  task automatic test_random(input int unsigned tx_pct, input int unsigned rx_pct,
                             input int unsigned n_chars);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    int unsigned idx;
    char_q_t     s;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_chars) begin
      pick = $urandom_range(99);
      s = routing_num(good_prefix(), $urandom_range(9999999));
      if (pick < 60) begin
        // good as built
      end else if (pick < 70) begin
        s[8] = CharW'(CharZero + (s[8] - CharZero + $urandom_range(9, 1)) % 10);
      end else if (pick < 78) begin
        s = routing_num(bad_prefix(), $urandom_range(9999999));
      end else if (pick < 88) begin
        do len = $urandom_range(14, 1); while (len == 9);
        s = digits({$urandom, $urandom}, len);
      end else if (pick < 96) begin
        idx = $urandom_range(8);
        if ($urandom_range(1)) s[idx] = non_digit();
        else s.insert(idx, non_digit());
      end else begin
        s.delete();
        len = $urandom_range(12, 1);
        repeat (len) s.push_back(CharW'($urandom_range(255)));
      end
      send_string(s);
      sent += s.size();
    end
    wait_all_results();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_shadow();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_valid_numbers();
    test_bad_chars();
    test_prefixes();
    test_checksum();
    test_lengths();

    test_random(0, 0, 400);
    test_random(80, 0, 350);
    test_random(0, 80, 350);
    test_random(13, 13, 400);

    // give the block room for a stray late result
    repeat (20) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
